### sv/assert_macros.svh
// Assertion macros shared by the RTL of the rectangle rotator.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define RRAC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rrac assertion failed");

// next-cycle implication, checked through reset as well
`define RRAC_ASSERT_NXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rrac assertion failed");

`endif

### sv/rrac_pkg.sv
// Types, widths and constants of the rectangle rotator.
// No dependencies; used by all modules and the testbench.
`default_nettype none
package rrac_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int TRIG_FRAC   = ((62 - COORD_WIDTH) < 24) ? (62 - COORD_WIDTH) : 24;
  localparam int CORDIC_FRAC = 30;
  localparam int CORDIC_W    = 34;
  localparam int TRIG_W      = TRIG_FRAC + 2;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = DIFF_W + TRIG_W;
  localparam int SUM_W       = PROD_W + 1;
  localparam int RND_W       = SUM_W - TRIG_FRAC + 1;
  localparam int RES_W       = RND_W + 1;
  localparam int ATAN_DEPTH  = 24;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd16384;
  localparam logic signed [16:0] HALF_TURN    = 17'sd32768;
  localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [15:0]            angle;
    logic signed [COORD_WIDTH-1:0] corner0_x;
    logic signed [COORD_WIDTH-1:0] corner0_y;
    logic signed [COORD_WIDTH-1:0] corner1_x;
    logic signed [COORD_WIDTH-1:0] corner1_y;
    logic signed [COORD_WIDTH-1:0] corner2_x;
    logic signed [COORD_WIDTH-1:0] corner2_y;
    logic signed [COORD_WIDTH-1:0] corner3_x;
    logic signed [COORD_WIDTH-1:0] corner3_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] out0_x;
    logic signed [COORD_WIDTH-1:0] out0_y;
    logic signed [COORD_WIDTH-1:0] out1_x;
    logic signed [COORD_WIDTH-1:0] out1_y;
    logic signed [COORD_WIDTH-1:0] out2_x;
    logic signed [COORD_WIDTH-1:0] out2_y;
    logic signed [COORD_WIDTH-1:0] out3_x;
    logic signed [COORD_WIDTH-1:0] out3_y;
    logic                          saturated;
  } out_item_t;

  // corner offsets and centre, plus the folded angle
  typedef struct packed {
    logic                          flip;
    logic signed [CORDIC_W-1:0]    z;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic [3:0][DIFF_W-1:0]        dx;
    logic [3:0][DIFF_W-1:0]        dy;
  } prep_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic [3:0][DIFF_W-1:0]        dx;
    logic [3:0][DIFF_W-1:0]        dy;
    logic signed [TRIG_W-1:0]      c;
    logic signed [TRIG_W-1:0]      s;
  } trig_item_t;

  // atan(2^-i) in 2^32-per-turn units
  function automatic logic signed [CORDIC_W-1:0] atan_entry(input int unsigned idx);
    logic signed [CORDIC_W-1:0] val;
    case (idx)
      0:       val = 34'sd536870912;
      1:       val = 34'sd316933406;
      2:       val = 34'sd167458907;
      3:       val = 34'sd85004756;
      4:       val = 34'sd42667331;
      5:       val = 34'sd21354465;
      6:       val = 34'sd10679838;
      7:       val = 34'sd5340245;
      8:       val = 34'sd2670163;
      9:       val = 34'sd1335087;
      10:      val = 34'sd667544;
      11:      val = 34'sd333772;
      12:      val = 34'sd166886;
      13:      val = 34'sd83443;
      14:      val = 34'sd41722;
      15:      val = 34'sd20861;
      16:      val = 34'sd10430;
      17:      val = 34'sd5215;
      18:      val = 34'sd2608;
      19:      val = 34'sd1304;
      20:      val = 34'sd652;
      21:      val = 34'sd326;
      22:      val = 34'sd163;
      23:      val = 34'sd81;
      default: val = '0;
    endcase
    return val;
  endfunction

  // true when some coordinate of a result sits at a range limit
  function automatic logic any_at_limit(input out_item_t r);
    return (r.out0_x == COORD_MAX) || (r.out0_x == COORD_MIN) ||
           (r.out0_y == COORD_MAX) || (r.out0_y == COORD_MIN) ||
           (r.out1_x == COORD_MAX) || (r.out1_x == COORD_MIN) ||
           (r.out1_y == COORD_MAX) || (r.out1_y == COORD_MIN) ||
           (r.out2_x == COORD_MAX) || (r.out2_x == COORD_MIN) ||
           (r.out2_y == COORD_MAX) || (r.out2_y == COORD_MIN) ||
           (r.out3_x == COORD_MAX) || (r.out3_x == COORD_MIN) ||
           (r.out3_y == COORD_MAX) || (r.out3_y == COORD_MIN);
  endfunction

endpackage
`default_nettype wire

### sv/rrac_stream_if.sv
// Valid/ready stream interface carrying one item of type item_t.
// Depends on nothing; item types come from rrac_pkg.
`default_nettype none
interface rrac_stream_if #(parameter type item_t = logic) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### sv/rrac_prep.sv
// Front end: centre of corners 0 and 2, corner offsets, angle fold.
// Two register stages. Depends on rrac_pkg and rrac_stream_if.
`default_nettype none
module rrac_prep (
  input  wire logic clk,
  input  wire logic rst,
  rrac_stream_if.sink   rect,
  rrac_stream_if.source prep
);
  import rrac_pkg::*;

  typedef struct packed {
    logic                          flip;
    logic signed [CORDIC_W-1:0]    z;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic [3:0][COORD_WIDTH-1:0]   px;
    logic [3:0][COORD_WIDTH-1:0]   py;
  } cent_t;

  logic [1:0] v;
  logic [1:0] en;
  cent_t      st0;
  cent_t      st0_next;
  prep_item_t st1;
  prep_item_t st1_next;

  assign en[1]      = !v[1] || prep.ready;
  assign en[0]      = !v[0] || en[1];
  assign rect.ready = en[0];
  assign prep.valid = v[1];
  assign prep.data  = st1;

  always_comb begin
    logic signed [COORD_WIDTH:0] sx;
    logic signed [COORD_WIDTH:0] sy;
    logic signed [16:0]          a;
    sx = {rect.data.corner0_x[COORD_WIDTH-1], rect.data.corner0_x} +
         {rect.data.corner2_x[COORD_WIDTH-1], rect.data.corner2_x};
    sy = {rect.data.corner0_y[COORD_WIDTH-1], rect.data.corner0_y} +
         {rect.data.corner2_y[COORD_WIDTH-1], rect.data.corner2_y};
    // floor of the half sum
    st0_next.cx = sx[COORD_WIDTH:1];
    st0_next.cy = sy[COORD_WIDTH:1];
    st0_next.px = {rect.data.corner3_x, rect.data.corner2_x,
                   rect.data.corner1_x, rect.data.corner0_x};
    st0_next.py = {rect.data.corner3_y, rect.data.corner2_y,
                   rect.data.corner1_y, rect.data.corner0_y};
    // bring the angle into +-quarter turn, negate the result later
    a = {rect.data.angle[15], rect.data.angle};
    st0_next.flip = 1'b0;
    if (a > QUARTER_TURN) begin
      a = a - HALF_TURN;
      st0_next.flip = 1'b1;
    end else if (a < -QUARTER_TURN) begin
      a = a + HALF_TURN;
      st0_next.flip = 1'b1;
    end
    st0_next.z = {a[16], a, 16'b0};
  end

  always_comb begin
    st1_next.flip = st0.flip;
    st1_next.z    = st0.z;
    st1_next.cx   = st0.cx;
    st1_next.cy   = st0.cy;
    for (int k = 0; k < 4; k++) begin
      st1_next.dx[k] = {st0.px[k][COORD_WIDTH-1], st0.px[k]} - {st0.cx[COORD_WIDTH-1], st0.cx};
      st1_next.dy[k] = {st0.py[k][COORD_WIDTH-1], st0.py[k]} - {st0.cy[COORD_WIDTH-1], st0.cy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= rect.valid;
      if (en[1]) v[1] <= v[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) st0 <= st0_next;
    if (en[1]) st1 <= st1_next;
  end

endmodule
`default_nettype wire

### sv/rrac_cordic.sv
// Pipelined CORDIC rotator: one micro-rotation per stage, then rounding
// of cosine and sine. Depends on rrac_pkg and rrac_stream_if.
`default_nettype none
module rrac_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  rrac_stream_if.sink   prep,
  rrac_stream_if.source trig
);
  import rrac_pkg::*;

  localparam int N  = STAGES + 1;
  localparam int SH = CORDIC_FRAC - TRIG_FRAC;
  localparam int RW = CORDIC_W - SH + 1;

  logic [N-1:0]               v;
  logic [N-1:0]               en;
  logic signed [CORDIC_W-1:0] xr [STAGES];
  logic signed [CORDIC_W-1:0] yr [STAGES];
  logic signed [CORDIC_W-1:0] zr [STAGES];
  prep_item_t                 pr [STAGES];
  trig_item_t                 tr;
  trig_item_t                 tr_next;

  assign en[N-1]    = !v[N-1] || trig.ready;
  assign prep.ready = en[0];
  assign trig.valid = v[N-1];
  assign trig.data  = tr;

  for (genvar i = 0; i < N - 1; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [CORDIC_W-1:0] xi;
    logic signed [CORDIC_W-1:0] yi;
    logic signed [CORDIC_W-1:0] zi;
    logic                       vi;
    prep_item_t                 pi;
    if (i == 0) begin : g_first
      assign xi = CORDIC_GAIN;
      assign yi = '0;
      assign zi = prep.data.z;
      assign vi = prep.valid;
      assign pi = prep.data;
    end else begin : g_rest
      assign xi = xr[i-1];
      assign yi = yr[i-1];
      assign zi = zr[i-1];
      assign vi = v[i-1];
      assign pi = pr[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en[i]) begin
        v[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        pr[i] <= pi;
        if (!zi[CORDIC_W-1]) begin
          xr[i] <= xi - (yi >>> i);
          yr[i] <= yi + (xi >>> i);
          zr[i] <= zi - atan_entry(i);
        end else begin
          xr[i] <= xi + (yi >>> i);
          yr[i] <= yi - (xi >>> i);
          zr[i] <= zi + atan_entry(i);
        end
      end
    end
  end

  always_comb begin
    logic signed [RW-1:0] cr;
    logic signed [RW-1:0] sr;
    logic signed [RW-1:0] lim;
    lim = RW'(1) <<< TRIG_FRAC;
    // round half up, clamp to +-1.0, then negate if the angle was folded
    cr = {xr[STAGES-1][CORDIC_W-1], xr[STAGES-1][CORDIC_W-1:SH]} +
         RW'(xr[STAGES-1][SH-1]);
    sr = {yr[STAGES-1][CORDIC_W-1], yr[STAGES-1][CORDIC_W-1:SH]} +
         RW'(yr[STAGES-1][SH-1]);
    if (cr > lim) cr = lim;
    if (cr < -lim) cr = -lim;
    if (sr > lim) sr = lim;
    if (sr < -lim) sr = -lim;
    if (pr[STAGES-1].flip) begin
      cr = -cr;
      sr = -sr;
    end
    tr_next.c  = cr[TRIG_W-1:0];
    tr_next.s  = sr[TRIG_W-1:0];
    tr_next.cx = pr[STAGES-1].cx;
    tr_next.cy = pr[STAGES-1].cy;
    tr_next.dx = pr[STAGES-1].dx;
    tr_next.dy = pr[STAGES-1].dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[N-1] <= 1'b0;
    end else if (en[N-1]) begin
      v[N-1] <= v[N-2];
    end
  end

  always_ff @(posedge clk) begin
    if (en[N-1]) tr <= tr_next;
  end

endmodule
`default_nettype wire

### sv/rrac_rotate.sv
// Back end: rotate the offsets by (c, s), round, add the centre, clamp.
// Three register stages. Depends on rrac_pkg and rrac_stream_if.
`default_nettype none
module rrac_rotate (
  input  wire logic clk,
  input  wire logic rst,
  rrac_stream_if.sink   trig,
  rrac_stream_if.source result
);
  import rrac_pkg::*;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic [3:0][PROD_W-1:0]        xc;
    logic [3:0][PROD_W-1:0]        ys;
    logic [3:0][PROD_W-1:0]        xs;
    logic [3:0][PROD_W-1:0]        yc;
  } prod_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic [3:0][RND_W-1:0]         rx;
    logic [3:0][RND_W-1:0]         ry;
  } rnd_t;

  logic [2:0] v;
  logic [2:0] en;
  prod_t      st0;
  prod_t      st0_next;
  rnd_t       st1;
  rnd_t       st1_next;
  out_item_t  st2;
  out_item_t  st2_next;

  assign en[2]        = !v[2] || result.ready;
  assign en[1]        = !v[1] || en[2];
  assign en[0]        = !v[0] || en[1];
  assign trig.ready   = en[0];
  assign result.valid = v[2];
  assign result.data  = st2;

  always_comb begin
    st0_next.cx = trig.data.cx;
    st0_next.cy = trig.data.cy;
    for (int k = 0; k < 4; k++) begin
      st0_next.xc[k] = $signed(trig.data.dx[k]) * trig.data.c;
      st0_next.ys[k] = $signed(trig.data.dy[k]) * trig.data.s;
      st0_next.xs[k] = $signed(trig.data.dx[k]) * trig.data.s;
      st0_next.yc[k] = $signed(trig.data.dy[k]) * trig.data.c;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] ax;
    logic signed [SUM_W-1:0] ay;
    st1_next.cx = st0.cx;
    st1_next.cy = st0.cy;
    for (int k = 0; k < 4; k++) begin
      ax = SUM_W'($signed(st0.xc[k])) - SUM_W'($signed(st0.ys[k]));
      ay = SUM_W'($signed(st0.xs[k])) + SUM_W'($signed(st0.yc[k]));
      // round half up to the coordinate fraction
      st1_next.rx[k] = {ax[SUM_W-1], ax[SUM_W-1:TRIG_FRAC]} + RND_W'(ax[TRIG_FRAC-1]);
      st1_next.ry[k] = {ay[SUM_W-1], ay[SUM_W-1:TRIG_FRAC]} + RND_W'(ay[TRIG_FRAC-1]);
    end
  end

  always_comb begin
    logic signed [RES_W-1:0]       r;
    logic [7:0]                    clip;
    logic [7:0][COORD_WIDTH-1:0]   val;
    for (int j = 0; j < 8; j++) begin
      if (j[0]) begin
        r = RES_W'(st1.cy) + RES_W'($signed(st1.ry[j/2]));
      end else begin
        r = RES_W'(st1.cx) + RES_W'($signed(st1.rx[j/2]));
      end
      clip[j] = 1'b1;
      if (r > RES_W'(COORD_MAX)) begin
        val[j] = COORD_MAX;
      end else if (r < RES_W'(COORD_MIN)) begin
        val[j] = COORD_MIN;
      end else begin
        val[j]  = r[COORD_WIDTH-1:0];
        clip[j] = 1'b0;
      end
    end
    st2_next.out0_x    = val[0];
    st2_next.out0_y    = val[1];
    st2_next.out1_x    = val[2];
    st2_next.out1_y    = val[3];
    st2_next.out2_x    = val[4];
    st2_next.out2_y    = val[5];
    st2_next.out3_x    = val[6];
    st2_next.out3_y    = val[7];
    st2_next.saturated = |clip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= trig.valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) st0 <= st0_next;
    if (en[1]) st1 <= st1_next;
    if (en[2]) st2 <= st2_next;
  end

endmodule
`default_nettype wire

### sv/rectangle_rotate_about_center_core.sv
// Rotates the four corners of a rectangle about the centre of corners 0 and 2.
// rect (sink): angle in binary units (65536 per turn) and four Q16.16 corners.
// result (source): four rotated Q16.16 corners and a flag set when any
// coordinate was clamped to the signed 32-bit range.
// Both channels move an item when valid and ready are high at a clock edge.
// The pipeline has two front-end stages for centre and offsets, one stage
// per CORDIC micro-rotation plus one for rounding, and three back-end
// stages for multiply, round and clamp. Throughput is one item per cycle
// as long as the result side keeps ready high.
// Each stage holds its item when the next one is full and stalled, and empty
// stages keep filling, so the block takes new items while a result waits
// until every stage holds one.
// Synchronous reset clears the valid bits and so empties the pipeline; the data registers are not reset.
// Depends on rrac_pkg, rrac_stream_if, rrac_prep, rrac_cordic, rrac_rotate.
`default_nettype none
`include "assert_macros.svh"
module rectangle_rotate_about_center_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  rrac_stream_if.sink   rect,
  rrac_stream_if.source result
);
  import rrac_pkg::*;

  rrac_stream_if #(.item_t(prep_item_t)) prep_ch ();
  rrac_stream_if #(.item_t(trig_item_t)) trig_ch ();

  rrac_prep u_prep (
    .clk  (clk),
    .rst  (rst),
    .rect (rect),
    .prep (prep_ch.source)
  );

  rrac_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .prep (prep_ch.sink),
    .trig (trig_ch.source)
  );

  rrac_rotate u_rotate (
    .clk    (clk),
    .rst    (rst),
    .trig   (trig_ch.sink),
    .result (result)
  );

  `RRAC_ASSERT_NXT(a_reset_empty, clk, rst, !result.valid)
  `RRAC_ASSERT_IMP(a_ready_chain, clk, rst, result.ready, rect.ready)
  `RRAC_ASSERT_IMP(a_sat_at_limit, clk, rst, result.valid && result.data.saturated,
                   any_at_limit(result.data))

endmodule
`default_nettype wire

### tb/tb_rectangle_rotate_about_center_core.sv
// Testbench for rectangle_rotate_about_center_core: drives rectangles and angles
// through the valid/ready interfaces and checks each result against a local predictor.
// Depends on rrac_pkg, rrac_stream_if and the core RTL.
`default_nettype none
module tb_rectangle_rotate_about_center_core;
  timeunit 1ns;
  timeprecision 1ps;
  import rrac_pkg::*;

  localparam int NUM_DIRECTED = 14;
  localparam int NUM_RANDOM   = 1440;
  localparam int STALL_LIMIT  = 2000;
  localparam int LATENCY      = 22;

  logic clk;
  logic rst;
  rrac_stream_if #(.item_t(in_item_t))  rect_if ();
  rrac_stream_if #(.item_t(out_item_t)) res_if ();

  rectangle_rotate_about_center_core u_top (
    .clk(clk), .rst(rst), .rect(rect_if.sink), .result(res_if.source)
  );

  out_item_t rotated_q[$];
  int        n_fail;
  int        idle_cycles;
  bit        quiet_phase;
  bit        hold_off;
  bit        stim_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint floor_sh(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint round_half_up(longint v, int n);
    return (v >>> n) + ((v >>> (n - 1)) & 1);
  endfunction

  function automatic longint clamp_unit(longint v);
    longint lim;
    lim = longint'(1) << TRIG_FRAC;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic signed [31:0] clamp_coord(longint v, ref logic flag);
    if (v > 64'sd2147483647) begin
      flag = 1'b1;
      return COORD_MAX;
    end
    if (v < -64'sd2147483648) begin
      flag = 1'b1;
      return COORD_MIN;
    end
    return v[31:0];
  endfunction

  function automatic out_item_t rotate_rect(in_item_t it);
    out_item_t r;
    longint px[4], py[4], cx, cy, cs, sn, x, y, z, xs, ys, a, dx, dy;
    logic [3:0][31:0] ox, oy;
    logic flag;
    bit flip;
    px[0] = it.corner0_x; py[0] = it.corner0_y;
    px[1] = it.corner1_x; py[1] = it.corner1_y;
    px[2] = it.corner2_x; py[2] = it.corner2_y;
    px[3] = it.corner3_x; py[3] = it.corner3_y;
    cx = floor_sh(px[0] + px[2], 1);
    cy = floor_sh(py[0] + py[2], 1);
    a = it.angle;
    flip = 1'b0;
    // fold into the right half plane, negate afterwards
    if (a > 16384) begin
      a -= 32768;
      flip = 1'b1;
    end else if (a < -16384) begin
      a += 32768;
      flip = 1'b1;
    end
    x = 652032874;
    y = 0;
    z = a * 65536;
    for (int i = 0; i < 16; i++) begin
      xs = floor_sh(x, i);
      ys = floor_sh(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= atan_entry(i);
      end else begin
        x += ys; y -= xs; z += atan_entry(i);
      end
    end
    cs = clamp_unit(round_half_up(x, CORDIC_FRAC - TRIG_FRAC));
    sn = clamp_unit(round_half_up(y, CORDIC_FRAC - TRIG_FRAC));
    if (flip) begin
      cs = -cs;
      sn = -sn;
    end
    flag = 1'b0;
    for (int k = 0; k < 4; k++) begin
      dx = px[k] - cx;
      dy = py[k] - cy;
      ox[k] = clamp_coord(cx + round_half_up(dx * cs - dy * sn, TRIG_FRAC), flag);
      oy[k] = clamp_coord(cy + round_half_up(dx * sn + dy * cs, TRIG_FRAC), flag);
    end
    r.out0_x = ox[0]; r.out0_y = oy[0];
    r.out1_x = ox[1]; r.out1_y = oy[1];
    r.out2_x = ox[2]; r.out2_y = oy[2];
    r.out3_x = ox[3]; r.out3_y = oy[3];
    r.saturated = flag;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return {{16{1'b0}}, 16'($urandom())} - 32'h8000;
      2:       return $urandom_range(0, 1) ? COORD_MAX - $urandom_range(0, 255)
                                           : COORD_MIN + $urandom_range(0, 255);
      default: return $signed(32'($urandom_range(0, 32'h0400_0000))) - 32'sh0200_0000;
    endcase
  endfunction

  // random angle with a rectangle of random size and placement, or with four random corners in one case of four
  function automatic in_item_t rand_rect();
    in_item_t it;
    logic signed [31:0] ox, oy, w, h;
    it.angle = 16'($urandom());
    if ($urandom_range(0, 3) == 0) begin
      it.corner0_x = rand_coord(); it.corner0_y = rand_coord();
      it.corner1_x = rand_coord(); it.corner1_y = rand_coord();
      it.corner2_x = rand_coord(); it.corner2_y = rand_coord();
      it.corner3_x = rand_coord(); it.corner3_y = rand_coord();
    end else begin
      ox = rand_coord();
      oy = rand_coord();
      w = $signed(32'($urandom_range(0, 32'h0100_0000))) - 32'sh0080_0000;
      h = $signed(32'($urandom_range(0, 32'h0100_0000))) - 32'sh0080_0000;
      it.corner0_x = ox;     it.corner0_y = oy;
      it.corner1_x = ox + w; it.corner1_y = oy;
      it.corner2_x = ox + w; it.corner2_y = oy + h;
      it.corner3_x = ox;     it.corner3_y = oy + h;
    end
    return it;
  endfunction

  in_item_t  directed_rect[NUM_DIRECTED];
  out_item_t directed_want[NUM_DIRECTED];
  bit        directed_known[NUM_DIRECTED];

  task automatic fill_table();
    in_item_t it;
    for (int i = 0; i < NUM_DIRECTED; i++) directed_known[i] = 1'b0;
    // zero rectangle at zero angle stays at zero
    it = '0;
    directed_rect[0] = it;
    directed_want[0] = '0;
    directed_known[0] = 1'b1;
    it = '0;
    it.corner0_x = -32'sh0001_0000; it.corner0_y = -32'sh0001_0000;
    it.corner1_x =  32'sh0001_0000; it.corner1_y = -32'sh0001_0000;
    it.corner2_x =  32'sh0001_0000; it.corner2_y =  32'sh0001_0000;
    it.corner3_x = -32'sh0001_0000; it.corner3_y =  32'sh0001_0000;
    directed_rect[1] = it;
    it.angle = 16'sh4000;  directed_rect[2] = it;
    it.angle = 16'sh7fff;  directed_rect[3] = it;
    it.angle = -16'sh8000; directed_rect[4] = it;
    it.angle = -16'sh4000; directed_rect[5] = it;
    it.angle = 16'sh4001;  directed_rect[6] = it;
    // far corners: rotation leaves the range and clamps
    it.angle = 16'sh2000;
    it.corner0_x = COORD_MIN; it.corner0_y = COORD_MIN;
    it.corner1_x = COORD_MAX; it.corner1_y = COORD_MIN;
    it.corner2_x = COORD_MAX; it.corner2_y = COORD_MAX;
    it.corner3_x = COORD_MIN; it.corner3_y = COORD_MAX;
    directed_rect[7] = it;
    it.angle = 16'sh4000;  directed_rect[8] = it;
    it = '1;
    directed_rect[9] = it;
    // odd sum of corners 0 and 2
    it = '0;
    it.angle = 16'sh1234;
    it.corner0_x = 32'sd3; it.corner0_y = -32'sd3;
    it.corner2_x = 32'sd0; it.corner2_y = 32'sd0;
    it.corner1_x = 32'sh0010_0000; it.corner3_y = -32'sh0033_0000;
    directed_rect[10] = it;
    // not a rectangle
    it.corner1_x = 32'sh1234_5678; it.corner1_y = -32'sh0765_4321;
    it.corner3_x = -32'sh0000_ffff;
    directed_rect[11] = it;
    it = '0;
    it.corner0_x = COORD_MAX; it.corner2_x = COORD_MAX;
    it.corner0_y = COORD_MIN; it.corner2_y = COORD_MIN;
    it.corner1_x = COORD_MIN; it.corner3_y = COORD_MAX;
    it.angle = -16'sd1;
    directed_rect[12] = it;
    it.angle = 16'sd1;
    directed_rect[13] = it;
  endtask

  task automatic send_rect(in_item_t it, out_item_t want, bit known);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 6);
      rect_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rect_if.valid <= 1'b1;
    rect_if.data  <= it;
    rotated_q.push_back(known ? want : rotate_rect(it));
    @(posedge clk);
    while (!rect_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    rst = 1'b1;
    rect_if.valid = 1'b0;
    rect_if.data = '0;
    res_if.ready = 1'b0;
    n_fail = 0;
    quiet_phase = 1'b0;
    hold_off = 1'b0;
    stim_done = 1'b0;
    fill_table();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    for (int i = 0; i < NUM_DIRECTED; i++)
      send_rect(directed_rect[i], directed_want[i], directed_known[i]);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == 200) hold_off = 1'b1;
      if (i == NUM_RANDOM - 200) quiet_phase = 1'b1;
      send_rect(rand_rect(), '0, 1'b0);
    end
    rect_if.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        res_if.ready <= 1'b0;
        repeat (80) @(negedge clk);
        hold_off = 1'b0;
      end
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 6);
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic cmp(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
      n_fail++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t w, g;
    if (!rst && res_if.valid && res_if.ready) begin
      g = res_if.data;
      if (rotated_q.size() == 0) begin
        $error("result with no rectangle outstanding");
        n_fail++;
      end else begin
        w = rotated_q.pop_front();
        cmp("out0_x", w.out0_x, g.out0_x);
        cmp("out0_y", w.out0_y, g.out0_y);
        cmp("out1_x", w.out1_x, g.out1_x);
        cmp("out1_y", w.out1_y, g.out1_y);
        cmp("out2_x", w.out2_x, g.out2_x);
        cmp("out2_y", w.out2_y, g.out2_y);
        cmp("out3_x", w.out3_x, g.out3_x);
        cmp("out3_y", w.out3_y, g.out3_y);
        cmp("saturated", 32'(w.saturated), 32'(g.saturated));
      end
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (rect_if.valid && rect_if.ready) || (res_if.valid && res_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (n_fail == 0 && rotated_q.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
